### design/tga_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// Used by the queue front end, the decode back end and the top level.
// Depends on nothing.
package tga_pkg;

  // Packet modes of the decoder.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RAW  = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  // Header thresholds: headers from RUN_FLAG upward open a run packet.
  localparam logic [7:0] RUN_FLAG = 8'd128;
  localparam logic [7:0] RUN_BIAS = 8'd127;

  // Result status codes.
  localparam logic [1:0] ST_PIXEL     = 2'd0;
  localparam logic [1:0] ST_TOO_MANY  = 2'd1;
  localparam logic [1:0] ST_EARLY_END = 2'd2;

  // Configuration register indexes.
  localparam logic REG_BYTES_PER_PIXEL = 1'b0;
  localparam logic REG_PIXEL_TOTAL     = 1'b1;

  // Configuration reset values.
  localparam logic [2:0]  BPP_RESET   = 3'd3;
  localparam logic [31:0] TOTAL_RESET = 32'd1;
  localparam logic [2:0]  BPP_FOUR    = 3'd4;

  // Depth of the byte queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // One queued stream byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } stream_entry_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic          valid;
    stream_entry_t entry;
  } queue_head_t;

  // Active configuration.
  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic [31:0] pixel_total;
  } cfg_t;

  // One result request.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic [1:0] status;
    logic       image_done;
  } result_t;

endpackage

### design/tga_in_if.sv
// Input channel of the TGA decoder: one stream byte per request.
// Valid/ready handshake; no package dependency.
interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

### design/tga_out_if.sv
// Output channel of the TGA decoder: one decoded pixel or error per request.
// Valid/ready handshake; no package dependency.
interface tga_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_count;
  logic [1:0] status;
  logic       image_done;

  modport source (
    output valid, output red, output green, output blue, output alpha,
    output repeat_count, output status, output image_done, input ready
  );
  modport sink (
    input valid, input red, input green, input blue, input alpha,
    input repeat_count, input status, input image_done, output ready
  );
endinterface

### design/tga_fe.sv
// Front end of the TGA decoder: accepts stream bytes into a short queue.
// Depends on tga_pkg and tga_in_if.
module tga_fe #(
  parameter int QueueDepth = tga_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  tga_in_if.sink              byte_stream,
  output tga_pkg::queue_head_t head,
  input  logic                pop
);
  import tga_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  stream_entry_t queue_mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            push;
  logic            do_pop;

  // Accept while there is room in the queue.
  assign byte_stream.ready = (fill != CntW'(QueueDepth));
  assign push   = byte_stream.valid && byte_stream.ready;
  assign do_pop = pop && (fill != '0);

  // Head of the queue for the back end.
  assign head.valid = (fill != '0);
  assign head.entry = queue_mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= '{data_byte: byte_stream.data_byte,
                             end_of_input: byte_stream.end_of_input};
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end
endmodule

### design/tga_be.sv
// Back end of the TGA decoder: packet state, pixel assembly, counting and
// the output register. Depends on tga_pkg and tga_out_if.
module tga_be (
  input  logic                clk,
  input  logic                rst,
  input  tga_pkg::cfg_t       cfg,
  input  tga_pkg::queue_head_t head,
  output logic                pop,
  tga_out_if.source           pixel_out
);
  import tga_pkg::*;

  logic [1:0]  packet_mode, packet_mode_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [31:0] pixel_bytes, pixel_bytes_next;
  logic [31:0] pixels_done, pixels_done_next;

  logic        out_valid;
  result_t     out_data;
  logic        emit;
  result_t     res;

  logic        can_load;
  logic [7:0]  b;
  logic        eoi;
  logic        bpp4;
  logic [2:0]  bpp;
  logic [1:0]  bip_inc;
  logic [31:0] pb_merged;
  logic [7:0]  count;
  logic [32:0] next_done;
  logic [32:0] total_ext;
  logic        done;

  // Take a byte when the output register is free or being drained.
  assign can_load = !out_valid || pixel_out.ready;
  assign pop      = head.valid && can_load;

  assign b    = head.entry.data_byte;
  assign eoi  = head.entry.end_of_input;
  assign bpp4 = (cfg.bytes_per_pixel == BPP_FOUR);
  assign bpp  = bpp4 ? 3'd4 : 3'd3;

  // Merge the new byte into the pixel at its byte lane.
  always_comb begin
    pb_merged = pixel_bytes;
    case (byte_in_pixel)
      2'd0:    pb_merged[7:0]   = pixel_bytes[7:0]   | b;
      2'd1:    pb_merged[15:8]  = pixel_bytes[15:8]  | b;
      2'd2:    pb_merged[23:16] = pixel_bytes[23:16] | b;
      default: pb_merged[31:24] = pixel_bytes[31:24] | b;
    endcase
  end

  assign bip_inc   = byte_in_pixel + 2'd1;
  assign count     = (packet_mode == MODE_RUN) ? packet_left : 8'd1;
  assign next_done = {1'b0, pixels_done} + {25'd0, count};
  assign total_ext = {1'b0, cfg.pixel_total};
  assign done      = (next_done == total_ext);

  // Per-byte decode step.
  always_comb begin
    packet_mode_next   = packet_mode;
    packet_left_next   = packet_left;
    byte_in_pixel_next = byte_in_pixel;
    pixel_bytes_next   = pixel_bytes;
    pixels_done_next   = pixels_done;
    emit               = 1'b0;
    res                = '0;

    if (packet_mode != MODE_RAW && packet_mode != MODE_RUN) begin
      // Packet header.
      if (b < RUN_FLAG) begin
        packet_mode_next = MODE_RAW;
        packet_left_next = b + 8'd1;
      end else begin
        packet_mode_next = MODE_RUN;
        packet_left_next = b - RUN_BIAS;
      end
      byte_in_pixel_next = '0;
      pixel_bytes_next   = '0;
      if (eoi) begin
        emit       = 1'b1;
        res.status = ST_EARLY_END;
      end
    end else if (bip_inc != 2'd0 && {1'b0, bip_inc} < bpp) begin
      // Pixel still incomplete.
      pixel_bytes_next   = pb_merged;
      byte_in_pixel_next = bip_inc;
      if (eoi) begin
        emit       = 1'b1;
        res.status = ST_EARLY_END;
      end
    end else if (next_done > total_ext) begin
      emit       = 1'b1;
      res.status = ST_TOO_MANY;
    end else if (eoi && !done) begin
      emit       = 1'b1;
      res.status = ST_EARLY_END;
    end else begin
      // Complete pixel, file order B,G,R,A.
      emit             = 1'b1;
      res.red          = pb_merged[23:16];
      res.green        = pb_merged[15:8];
      res.blue         = pb_merged[7:0];
      res.alpha        = bpp4 ? pb_merged[31:24] : 8'd0;
      res.repeat_count = count;
      res.status       = ST_PIXEL;
      res.image_done   = done;
      pixels_done_next   = next_done[31:0];
      byte_in_pixel_next = '0;
      pixel_bytes_next   = '0;
      if (packet_mode == MODE_RUN || packet_left <= 8'd1) begin
        packet_left_next = '0;
        packet_mode_next = MODE_IDLE;
      end else begin
        packet_left_next = packet_left - 8'd1;
      end
    end

    // Errors and a finished image return to idle.
    if (emit && (res.status != ST_PIXEL || res.image_done)) begin
      packet_mode_next   = MODE_IDLE;
      packet_left_next   = '0;
      byte_in_pixel_next = '0;
      pixel_bytes_next   = '0;
      pixels_done_next   = '0;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_mode   <= MODE_IDLE;
      packet_left   <= '0;
      byte_in_pixel <= '0;
      pixel_bytes   <= '0;
      pixels_done   <= '0;
    end else if (pop) begin
      packet_mode   <= packet_mode_next;
      packet_left   <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_bytes   <= pixel_bytes_next;
      pixels_done   <= pixels_done_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= res;
    end
  end

  assign pixel_out.valid        = out_valid;
  assign pixel_out.red          = out_data.red;
  assign pixel_out.green        = out_data.green;
  assign pixel_out.blue         = out_data.blue;
  assign pixel_out.alpha        = out_data.alpha;
  assign pixel_out.repeat_count = out_data.repeat_count;
  assign pixel_out.status       = out_data.status;
  assign pixel_out.image_done   = out_data.image_done;
endmodule

### design/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: configuration registers,
// byte queue front end and decode back end. Depends on tga_pkg, tga_in_if,
// tga_out_if, tga_fe and tga_be.
//
//   channel      dir  handshake      payload
//   byte_stream  in   valid/ready    data_byte[7:0], end_of_input
//   pixel_out    out  valid/ready    red, green, blue, alpha, repeat_count,
//                                    status[1:0], image_done
//   wr_*         in   wr_en          wr_index (0 bytes_per_pixel, 1 pixel_total),
//                                    wr_data[31:0]
//
// One byte is accepted per cycle unless pixel_out stalls; each byte is held
// in the queue register and its result in the output register.
// The per-byte state update in the back end is a loop on its own state.
// Reset is synchronous and clears the queue, the decoder state and the
// configuration to 3 bytes per pixel and one pixel.
// A stall on pixel_out holds the back end; the queue absorbs QueueDepth
// bytes before byte_stream.ready drops.
module tga_rle_pixel_decoder #(
  parameter int QueueDepth = tga_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  tga_in_if.sink      byte_stream,
  tga_out_if.source   pixel_out,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data
);
  import tga_pkg::*;

  cfg_t        cfg;
  queue_head_t head;
  logic        pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_pixel <= BPP_RESET;
      cfg.pixel_total     <= TOTAL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= wr_data[2:0];
        default:             cfg.pixel_total     <= wr_data;
      endcase
    end
  end

  tga_fe #(
    .QueueDepth(QueueDepth)
  ) u_fe (
    .clk        (clk),
    .rst        (rst),
    .byte_stream(byte_stream),
    .head       (head),
    .pop        (pop)
  );

  tga_be u_be (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .pixel_out(pixel_out)
  );
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the TGA run-length pixel decoder.
// Drives byte streams with random idling on both channels and checks each result against
// a built-in decoder model. Depends on tga_pkg, tga_in_if, tga_out_if and the decoder RTL.
module tb_top;
  import tga_pkg::*;

  localparam int unsigned QUIET_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic        wr_index;
  logic [31:0] wr_data;

  tga_in_if  byte_ch ();
  tga_out_if pix_ch ();

  tga_rle_pixel_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_ch),
    .pixel_out   (pix_ch),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  // Model copy of the configuration and the decoder state.
  logic [2:0]  cfg_bpp   = BPP_RESET;
  logic [31:0] cfg_total = TOTAL_RESET;
  logic [1:0]  dec_mode;
  logic [7:0]  dec_left;
  logic [1:0]  dec_nbytes;
  logic [31:0] dec_pixel;
  logic [31:0] dec_count;

  // Results the decoder still owes, oldest first.
  result_t expected_pixels[$];
  result_t oldest_pixel;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned bytes_sent     = 0;
  int unsigned writes_done    = 0;
  int unsigned failures       = 0;
  int unsigned pixels_seen    = 0;
  int unsigned too_many_seen  = 0;
  int unsigned early_end_seen = 0;
  int unsigned quiet_cycles   = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Return the model to the idle state with the pixel count cleared.
  function automatic void clear_decoder();
    dec_mode   = MODE_IDLE;
    dec_left   = '0;
    dec_nbytes = '0;
    dec_pixel  = '0;
    dec_count  = '0;
  endfunction

  // Queue an error report and drop back to idle.
  function automatic void push_error(input logic [1:0] code);
    result_t r;
    r = '0;
    r.status = code;
    expected_pixels.push_back(r);
    clear_decoder();
  endfunction

  // Advance the model by one accepted stream byte.
  function automatic void decode_byte(input logic [7:0] b, input logic eoi);
    logic [2:0]  need;
    logic [7:0]  count;
    logic [32:0] next_total;
    logic        done;
    result_t     r;
    need = (cfg_bpp == BPP_FOUR) ? 3'd4 : 3'd3;
    // Outside a packet the byte is a packet header.
    if (dec_mode != MODE_RAW && dec_mode != MODE_RUN) begin
      if (b < RUN_FLAG) begin
        dec_mode = MODE_RAW;
        dec_left = b + 8'd1;
      end else begin
        dec_mode = MODE_RUN;
        dec_left = b - RUN_BIAS;
      end
      dec_nbytes = '0;
      dec_pixel  = '0;
      if (eoi) push_error(ST_EARLY_END);
      return;
    end
    // Collect pixel bytes until the current format says the pixel is complete.
    dec_pixel  = dec_pixel | (32'(b) << (8 * dec_nbytes));
    dec_nbytes = dec_nbytes + 2'd1;
    if (dec_nbytes != 2'd0 && {1'b0, dec_nbytes} < need) begin
      if (eoi) push_error(ST_EARLY_END);
      return;
    end
    // A complete pixel: overflow wins over an early end.
    count      = (dec_mode == MODE_RUN) ? dec_left : 8'd1;
    next_total = {1'b0, dec_count} + 33'(count);
    if (next_total > {1'b0, cfg_total}) begin
      push_error(ST_TOO_MANY);
      return;
    end
    done = (next_total == {1'b0, cfg_total});
    if (eoi && !done) begin
      push_error(ST_EARLY_END);
      return;
    end
    r.red          = dec_pixel[23:16];
    r.green        = dec_pixel[15:8];
    r.blue         = dec_pixel[7:0];
    r.alpha        = (need == 3'd4) ? dec_pixel[31:24] : 8'd0;
    r.repeat_count = count;
    r.status       = ST_PIXEL;
    r.image_done   = done;
    expected_pixels.push_back(r);
    if (done) begin
      clear_decoder();
      return;
    end
    dec_count  = next_total[31:0];
    dec_nbytes = '0;
    dec_pixel  = '0;
    if (dec_mode == MODE_RUN || dec_left <= 8'd1) begin
      dec_left = '0;
      dec_mode = MODE_IDLE;
    end else begin
      dec_left = dec_left - 8'd1;
    end
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result with nothing expected: status %0d", pix_ch.status);
        failures++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        compare_field("red", oldest_pixel.red, pix_ch.red);
        compare_field("green", oldest_pixel.green, pix_ch.green);
        compare_field("blue", oldest_pixel.blue, pix_ch.blue);
        compare_field("alpha", oldest_pixel.alpha, pix_ch.alpha);
        compare_field("repeat_count", oldest_pixel.repeat_count, pix_ch.repeat_count);
        compare_field("status", oldest_pixel.status, pix_ch.status);
        compare_field("image_done", oldest_pixel.image_done, pix_ch.image_done);
        case (oldest_pixel.status)
          ST_TOO_MANY:  too_many_seen++;
          ST_EARLY_END: early_end_seen++;
          default:      pixels_seen++;
        endcase
      end
    end
  end

  // Receiver side: random back-pressure on the result channel.
  always @(posedge clk) begin
    pix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: too long without any request moving on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_pixels.size());
      $display("FAIL");
      $finish;
    end
  end

  // Offer one stream byte, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data_byte    <= b;
    byte_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b, eoi);
    bytes_sent++;
  endtask

  // Stop sending, collect every owed result and let header-only bytes drain.
  task automatic wait_quiet();
    byte_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Register write, only with the decoder quiet.
  task automatic write_reg(input logic idx, input logic [31:0] data);
    wait_quiet();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    if (idx == REG_BYTES_PER_PIXEL) cfg_bpp = data[2:0];
    else cfg_total = data;
    writes_done++;
    wr_en <= 1'b0;
  endtask

  // An empty image: the first pixel overflows, even with end of input on it.
  task automatic test_zero_total();
    write_reg(REG_PIXEL_TOTAL, 32'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  // Longest raw packet with BGRA pixels, then the three flavors of early end.
  task automatic test_raw_early_end();
    write_reg(REG_BYTES_PER_PIXEL, 32'd4);
    write_reg(REG_PIXEL_TOTAL, 32'hFFFF_FFFF);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    // End on a byte that completes a pixel but not the image.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'hFC, 1'b1);
    // End on a header, then in the middle of a pixel.
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  // Longest and shortest run packets; the image ends on its final byte.
  task automatic test_run_image_done();
    write_reg(REG_BYTES_PER_PIXEL, 32'd7);
    write_reg(REG_PIXEL_TOTAL, 32'd129);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h50, 1'b0);
    send_byte(8'h60, 1'b1);
  endtask

  // Switch from four to three bytes per pixel with three bytes of a pixel received.
  task automatic test_format_change();
    write_reg(REG_BYTES_PER_PIXEL, 32'd4);
    write_reg(REG_PIXEL_TOTAL, 32'd2);
    send_byte(8'h01, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h0C, 1'b0);
    write_reg(REG_BYTES_PER_PIXEL, 32'd3);
    send_byte(8'h0D, 1'b0);
    send_byte(8'h0E, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h55, 1'b0);
  endtask

  // Build one image from random raw and run packets and send it; optionally the last
  // packet overflows the image, or end of input cuts the stream at a random byte.
  task automatic send_image(input bit overshoot, input bit truncate);
    logic [8:0]  stream_q[$];
    int unsigned placed;
    int unsigned target;
    int unsigned room;
    int unsigned n;
    int unsigned k;
    int unsigned cut;
    int unsigned nbytes;
    nbytes = (cfg_bpp == BPP_FOUR) ? 4 : 3;
    k = 0;
    if (cfg_total == 0) overshoot = 1'b1;
    if (overshoot && cfg_total != 0)
      k = $urandom_range(1, (cfg_total < 127) ? cfg_total : 127);
    target = cfg_total - k;
    placed = 0;
    while (placed < target) begin
      room = target - placed;
      if ($urandom_range(1) == 1) begin
        n = $urandom_range(1, (room < 128) ? room : 128);
        stream_q.push_back({1'b0, 8'(n + 127)});
        repeat (nbytes) stream_q.push_back({1'b0, 8'($urandom)});
      end else begin
        n = $urandom_range(1, (room < 6) ? room : 6);
        stream_q.push_back({1'b0, 8'(n - 1)});
        repeat (n * nbytes) stream_q.push_back({1'b0, 8'($urandom)});
      end
      placed += n;
    end
    if (overshoot) begin
      n = $urandom_range(k + 1, 128);
      stream_q.push_back({1'b0, 8'(n + 127)});
      repeat (nbytes) stream_q.push_back({1'b0, 8'($urandom)});
    end
    stream_q[stream_q.size() - 1][8] = 1'($urandom_range(1));
    if (truncate) begin
      cut = $urandom_range(0, stream_q.size() - 1);
      stream_q[cut][8] = 1'b1;
      while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
    end
    foreach (stream_q[i]) send_byte(stream_q[i][7:0], stream_q[i][8]);
  endtask

  // Mostly well-formed images with random content and formats, plus broken ones and noise.
  task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned s_idle,
                                     input int unsigned r_idle);
    int unsigned start;
    int unsigned pick;
    int unsigned new_total;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(2) == 0) begin
        if ($urandom_range(4) == 0) write_reg(REG_BYTES_PER_PIXEL, $urandom_range(7));
        else write_reg(REG_BYTES_PER_PIXEL, $urandom_range(1) ? 32'd4 : 32'd3);
        pick = $urandom_range(99);
        if (pick < 65) new_total = $urandom_range(1, 12);
        else if (pick < 92) new_total = $urandom_range(13, 300);
        else new_total = 0;
        write_reg(REG_PIXEL_TOTAL, new_total);
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(7) == 0);
      end else if (pick < 17) begin
        send_image(1'b1, 1'b0);
      end else if (pick < 26) begin
        send_image(1'b0, 1'b1);
      end else begin
        send_image(1'b0, 1'b0);
      end
      // Any byte flagged as the last one brings the decoder back to idle.
      if (dec_mode != MODE_IDLE || dec_count != 0) send_byte(8'($urandom), 1'b1);
    end
  endtask

  // Test sequence.
  initial begin
    rst                  <= 1'b1;
    wr_en                <= 1'b0;
    wr_index             <= 1'b0;
    wr_data              <= '0;
    byte_ch.valid        <= 1'b0;
    byte_ch.data_byte    <= '0;
    byte_ch.end_of_input <= 1'b0;
    clear_decoder();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_zero_total();
    test_raw_early_end();
    test_run_image_done();
    test_format_change();
    test_random_traffic(530, 7, 56);
    test_random_traffic(530, 56, 7);
    test_random_traffic(540, 0, 0);

    wait_quiet();
    $display("Sent %0d stream bytes in directed cases and three idling phases, %0d register writes.",
             bytes_sent, writes_done);
    $display("Checked %0d pixels, %0d overflow reports and %0d early-end reports.",
             pixels_seen, too_many_seen, early_end_seen);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
